// File: sv/tgrr_pkg.sv
// Package for the two-group round-robin task picker.
// Holds the action codes, the controller state type and the command/status structs.
// No dependencies.
package tgrr_pkg;

    // Number of task groups (fixed) and default slots per group
    localparam int GROUPS        = 2;
    localparam int SLOTS_DEFAULT = 8;

    // Input action codes
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_KILL  = 2'd1,
        ACT_START = 2'd2,
        ACT_POST  = 2'd3
    } action_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TRY,
        ST_RESULT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic edit;   // apply a kill, start or post word
        logic start;  // begin a tick: pick first group, clear result
        logic serve;  // admit and pick on the group under trial
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic found;  // group under trial has an alive slot after admission
    } status_t;

endpackage

// File: sv/tgrr_ctrl.sv
// Controller of the task picker: accepts words, sequences the group trials of
// a tick and holds the result word until taken. Depends on tgrr_pkg.
module tgrr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        action,
    output logic              out_valid,
    input  logic              out_stall,
    output tgrr_pkg::cmd_t    cmd,
    input  tgrr_pkg::status_t status
);
    import tgrr_pkg::*;

    state_t state_reg, state_next;
    logic   second_reg, second_next;
    logic   accept;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_RESULT);
    assign accept    = in_valid && (state_reg == ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_TICK)
                    begin
                        cmd.start   = 1'b1;
                        second_next = 1'b0;
                        state_next  = ST_TRY;
                    end
                    else
                    begin
                        cmd.edit = 1'b1;
                    end
                end
            end
            ST_TRY:
            begin
                cmd.serve = 1'b1;
                // advance to the other group only when this one has nothing alive
                if (status.found || second_reg)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    second_next = 1'b1;
                end
            end
            ST_RESULT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/tgrr_datapath.sv
// Datapath of the task picker: alive, has-run and pending marks per group,
// admission and pick logic, current group and result registers. Depends on tgrr_pkg.
module tgrr_datapath #(
    parameter int SLOTS = tgrr_pkg::SLOTS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tgrr_pkg::cmd_t     cmd,
    output tgrr_pkg::status_t  status,
    input  logic [1:0]         action,
    input  logic               group,
    input  logic [2:0]         slot,
    output logic               found,
    output logic               chosen_group,
    output logic [2:0]         chosen_slot,
    output logic               admitted,
    output logic [2:0]         admitted_slot
);
    import tgrr_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int CW = ($clog2(SLOTS + 1) > 3) ? $clog2(SLOTS + 1) : 3;

    // Lowest set bit of a slot vector
    function automatic logic [SW-1:0] low_idx(input logic [SLOTS-1:0] v);
        logic [SW-1:0] r;
        r = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = SW'(i);
            end
        end
        return r;
    endfunction

    // One-hot vector of a slot index
    function automatic logic [SLOTS-1:0] one_hot(input logic [SW-1:0] i);
        logic [SLOTS-1:0] r;
        r    = '0;
        r[i] = 1'b1;
        return r;
    endfunction

    logic [SLOTS-1:0] alive_reg [GROUPS];
    logic [SLOTS-1:0] alive_next [GROUPS];
    logic [SLOTS-1:0] run_reg [GROUPS];
    logic [SLOTS-1:0] run_next [GROUPS];
    logic [SLOTS-1:0] pend_reg [GROUPS];
    logic [SLOTS-1:0] pend_next [GROUPS];

    logic cur_grp_reg, cur_grp_next;
    logic try_grp_reg, try_grp_next;

    logic          found_reg, found_next;
    logic          chosen_group_reg, chosen_group_next;
    logic [2:0]    chosen_slot_reg, chosen_slot_next;
    logic          admitted_reg, admitted_next;
    logic [2:0]    admitted_slot_reg, admitted_slot_next;

    // Edit decode
    logic             in_range;
    logic [SLOTS-1:0] slot_oh;

    // Serve path
    logic [SLOTS-1:0] t_alive, t_run, t_pend;
    logic             do_adm;
    logic [SW-1:0]    pend_idx, dead_idx, pick_idx;
    logic [SLOTS-1:0] pend_oh, dead_oh;
    logic [SLOTS-1:0] alive_a, run_a, ready, run_n;
    logic             has_ready;

    // Decode the addressed slot; drop words beyond the slot count
    always_comb
    begin
        in_range = (CW'(slot) < CW'(SLOTS));
        slot_oh  = '0;
        if (in_range)
        begin
            slot_oh[SW'(slot)] = 1'b1;
        end
    end

    // Admission then pick on the group under trial
    always_comb
    begin
        t_alive   = alive_reg[try_grp_reg];
        t_run     = run_reg[try_grp_reg];
        t_pend    = pend_reg[try_grp_reg];
        do_adm    = (|t_pend) && (|(~t_alive));
        pend_idx  = low_idx(t_pend);
        dead_idx  = low_idx(~t_alive);
        pend_oh   = do_adm ? one_hot(pend_idx) : '0;
        dead_oh   = do_adm ? one_hot(dead_idx) : '0;
        alive_a   = t_alive | dead_oh;
        run_a     = t_run & ~dead_oh;
        ready     = alive_a & ~run_a;
        has_ready = |ready;
        pick_idx  = has_ready ? low_idx(ready) : low_idx(alive_a);
        run_n     = has_ready ? (run_a | one_hot(pick_idx)) : one_hot(pick_idx);
    end

    assign status.found = |alive_a;

    // Next state of marks, groups and result
    always_comb
    begin
        cur_grp_next       = cur_grp_reg;
        try_grp_next       = try_grp_reg;
        found_next         = found_reg;
        chosen_group_next  = chosen_group_reg;
        chosen_slot_next   = chosen_slot_reg;
        admitted_next      = admitted_reg;
        admitted_slot_next = admitted_slot_reg;
        for (int g = 0; g < GROUPS; g++)
        begin
            alive_next[g] = alive_reg[g];
            run_next[g]   = run_reg[g];
            pend_next[g]  = pend_reg[g];
            if (cmd.edit && (group == 1'(g)))
            begin
                case (action)
                    ACT_KILL:
                    begin
                        alive_next[g] = alive_reg[g] & ~slot_oh;
                    end
                    ACT_START:
                    begin
                        alive_next[g] = alive_reg[g] | slot_oh;
                        run_next[g]   = run_reg[g] & ~slot_oh;
                    end
                    ACT_POST:
                    begin
                        pend_next[g] = pend_reg[g] | slot_oh;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.serve && (try_grp_reg == 1'(g)))
            begin
                alive_next[g] = alive_a;
                pend_next[g]  = pend_reg[g] & ~pend_oh;
                run_next[g]   = status.found ? run_n : run_a;
            end
        end

        // Start a tick on the group after the current one
        if (cmd.start)
        begin
            try_grp_next       = ~cur_grp_reg;
            found_next         = 1'b0;
            chosen_group_next  = 1'b0;
            chosen_slot_next   = '0;
            admitted_next      = 1'b0;
            admitted_slot_next = '0;
        end

        if (cmd.serve)
        begin
            if (do_adm)
            begin
                admitted_next      = 1'b1;
                admitted_slot_next = 3'(dead_idx);
            end
            if (status.found)
            begin
                cur_grp_next      = try_grp_reg;
                found_next        = 1'b1;
                chosen_group_next = try_grp_reg;
                chosen_slot_next  = 3'(pick_idx);
            end
            else
            begin
                try_grp_next = ~try_grp_reg;
            end
        end
    end

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < GROUPS; g++)
            begin
                alive_reg[g] <= '0;
                run_reg[g]   <= '0;
                pend_reg[g]  <= '0;
            end
            cur_grp_reg       <= 1'b0;
            try_grp_reg       <= 1'b0;
            found_reg         <= 1'b0;
            chosen_group_reg  <= 1'b0;
            chosen_slot_reg   <= '0;
            admitted_reg      <= 1'b0;
            admitted_slot_reg <= '0;
        end
        else
        begin
            for (int g = 0; g < GROUPS; g++)
            begin
                alive_reg[g] <= alive_next[g];
                run_reg[g]   <= run_next[g];
                pend_reg[g]  <= pend_next[g];
            end
            cur_grp_reg       <= cur_grp_next;
            try_grp_reg       <= try_grp_next;
            found_reg         <= found_next;
            chosen_group_reg  <= chosen_group_next;
            chosen_slot_reg   <= chosen_slot_next;
            admitted_reg      <= admitted_next;
            admitted_slot_reg <= admitted_slot_next;
        end
    end

    assign found         = found_reg;
    assign chosen_group  = chosen_group_reg;
    assign chosen_slot   = chosen_slot_reg;
    assign admitted      = admitted_reg;
    assign admitted_slot = admitted_slot_reg;

endmodule

// File: sv/two_group_round_robin_task_picker_unit.sv
// Channel  Direction  Handshake           Fields
// in       input      in_valid/in_stall   action, group, slot
// out      output     out_valid/out_stall found, chosen_group, chosen_slot,
//                                         admitted, admitted_slot
//
// Kill, start and post words give no result word.
// A tick word is served by the admission/pick logic in one try state per group
// tried: the result is ready after one try, or after two when the first group
// tried has no alive slot.
// The result register holds the word while out_stall is high; in_stall is high
// from the cycle after a tick's acceptance until its result is taken.
// Reset (rst_n, async, active low) clears all marks and the current group.
// Top level of the task picker: controller and datapath. Depends on tgrr_pkg,
// tgrr_ctrl and tgrr_datapath.
module two_group_round_robin_task_picker_unit #(
    parameter int SLOTS = tgrr_pkg::SLOTS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] action,
    input  logic       group,
    input  logic [2:0] slot,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       found,
    output logic       chosen_group,
    output logic [2:0] chosen_slot,
    output logic       admitted,
    output logic [2:0] admitted_slot
);
    import tgrr_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequence words and tick trials
    tgrr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    // Hold marks and compute admission and pick
    tgrr_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .action        (action),
        .group         (group),
        .slot          (slot),
        .found         (found),
        .chosen_group  (chosen_group),
        .chosen_slot   (chosen_slot),
        .admitted      (admitted),
        .admitted_slot (admitted_slot)
    );

endmodule

// File: sv/tgrr_checker.sv
// Port-level checker for the task picker, bound to the top level.
// Depends on tgrr_pkg for the action codes.
module tgrr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [1:0] action,
    input logic       group,
    input logic [2:0] slot,
    input logic       out_valid,
    input logic       out_stall,
    input logic       found,
    input logic       chosen_group,
    input logic [2:0] chosen_slot,
    input logic       admitted,
    input logic [2:0] admitted_slot
);
    import tgrr_pkg::*;

    // A tick word blocks the input side on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (action == ACT_TICK)) |=> in_stall)
    else $error("tick accepted but input not stalled");

    // An edit word gives no result and leaves the input open
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (action != ACT_TICK)) |=> (!in_stall && !out_valid))
    else $error("edit word produced a result or stalled input");

    // No input is taken while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
    else $error("input open while result pending");

    // An admission always makes a task available
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && admitted) |-> found)
    else $error("admission reported on an idle result");

    // A stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(found)
            && $stable(chosen_group) && $stable(chosen_slot)
            && $stable(admitted) && $stable(admitted_slot)))
    else $error("stalled result word changed");

endmodule

bind two_group_round_robin_task_picker_unit tgrr_checker u_tgrr_checker (.*);
